// ===== design/jss_pkg.sv =====
package jss_pkg;

   localparam int MAX_DEPTH   = 16;
   localparam int LEVEL_W     = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W      = $clog2(MAX_DEPTH);
   localparam int CTX_W       = 4;
   localparam int ACT_SLOTS   = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int TAG_W       = 16;

   typedef enum logic [2:0] {
      OP_LIT  = 3'd0,
      OP_LARR = 3'd1,
      OP_LOBJ = 3'd2,
      OP_ARR  = 3'd3,
      OP_OBJ  = 3'd4,
      OP_END  = 3'd5,
      OP_FIN  = 3'd6,
      OP_LFIN = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      A_SPACE   = 4'd0,
      A_NEWLINE = 4'd1,
      A_IN      = 4'd2,
      A_OUT     = 4'd3,
      A_COMMA   = 4'd4,
      A_COLON   = 4'd5,
      A_LBRACK  = 4'd6,
      A_RBRACK  = 4'd7,
      A_LBRACE  = 4'd8,
      A_RBRACE  = 4'd9,
      A_LIT     = 4'd10,
      A_ERR     = 4'd11
   } action_type;

   typedef enum logic [2:0] {
      E_NONE      = 3'd0,
      E_BEGIN_KEY = 3'd1,
      E_END_KEY   = 3'd2,
      E_END_ROOT  = 3'd3,
      E_LIT_ROOT  = 3'd4,
      E_NOT_STR   = 3'd5,
      E_OVERFLOW  = 3'd6
   } err_type;

   typedef enum logic [CTX_W-1:0] {
      C_ROOT = 4'd0,
      C_LAB  = 4'd1,
      C_LAI  = 4'd2,
      C_LOB  = 4'd3,
      C_LOK  = 4'd4,
      C_LOV  = 4'd5,
      C_MAB  = 4'd6,
      C_MAI  = 4'd7,
      C_MOB  = 4'd8,
      C_MOK  = 4'd9,
      C_MOV  = 4'd10
   } ctx_type;

   // One queued command: a short run of actions that the back end plays out in order.
   typedef struct packed {
      logic [2:0]                   count;
      action_type [ACT_SLOTS-1:0]   act;
      logic [TAG_W-1:0]             tag;
      err_type                      err;
      logic                         last;
   } cmd_type;

   function automatic cmd_type err_cmd(input err_type code);
      cmd_type c;
      c        = '0;
      c.count  = 3'd1;
      c.act[0] = A_ERR;
      c.err    = code;
      c.last   = 1'b1;
      return c;
   endfunction

   function automatic cmd_type close_cmd(input ctx_type ctx, input logic last);
      cmd_type c;
      c      = '0;
      c.last = last;
      case (ctx)
         C_LAB: begin
            c.count = 3'd1; c.act[0] = A_RBRACK;
         end
         C_LAI: begin
            c.count = 3'd2; c.act[0] = A_SPACE; c.act[1] = A_RBRACK;
         end
         C_LOB: begin
            c.count = 3'd1; c.act[0] = A_RBRACE;
         end
         C_LOV: begin
            c.count = 3'd2; c.act[0] = A_SPACE; c.act[1] = A_RBRACE;
         end
         C_MAB: begin
            c.count = 3'd2; c.act[0] = A_OUT; c.act[1] = A_RBRACK;
         end
         C_MAI: begin
            c.count = 3'd3; c.act[0] = A_OUT; c.act[1] = A_NEWLINE; c.act[2] = A_RBRACK;
         end
         C_MOB: begin
            c.count = 3'd2; c.act[0] = A_OUT; c.act[1] = A_RBRACE;
         end
         C_MOV: begin
            c.count = 3'd3; c.act[0] = A_OUT; c.act[1] = A_NEWLINE; c.act[2] = A_RBRACE;
         end
         default: begin
            // Key-pending contexts never get here; emit nothing but a bracket.
            c.count = 3'd1; c.act[0] = A_RBRACE;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== design/jss_req_if.sv =====
interface jss_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic        is_string;
   logic [15:0] literal_handle;

   modport source (output valid, output op, output is_string, output literal_handle,
                   input ready);
   modport sink (input valid, input op, input is_string, input literal_handle,
                 output ready);
endinterface

// ===== design/jss_rsp_if.sv =====
interface jss_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [15:0] literal_tag;
   logic [2:0]  error_code;
   logic        last;

   modport source (output valid, output action, output literal_tag, output error_code,
                   output last, input ready);
   modport sink (input valid, input action, input literal_tag, input error_code,
                 input last, output ready);
endinterface

// ===== design/jss_ram.sv =====
module jss_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/jss_queue.sv =====
module jss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jss_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output jss_pkg::cmd_type pop_data,
   output logic             not_empty
);

   localparam int PTR_W = $clog2(jss_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(jss_pkg::QUEUE_DEPTH + 1);

   jss_pkg::cmd_type   mem_ff [jss_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(jss_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(jss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(jss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/jss_front.sv =====
module jss_front (
   input  logic             clock,
   input  logic             reset,
   jss_req_if.sink          req_chan,
   output logic             q_push,
   output jss_pkg::cmd_type q_data,
   input  logic             q_full
);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_FETCH     = 5'b00010,
      S_UNWIND    = 5'b00100,
      S_UNW_FETCH = 5'b01000,
      S_FINISH    = 5'b10000
   } front_state_type;

   front_state_type                state_ff, state_in;
   logic [jss_pkg::LEVEL_W-1:0]    level_ff, level_in;
   jss_pkg::ctx_type               top_ff, top_in;
   logic                           linear_ff, linear_in;

   logic [jss_pkg::LEVEL_W-1:0]    level_m1, level_m2;
   logic                           wr_en;
   logic [jss_pkg::ADDR_W-1:0]     wr_addr, rd_addr;
   jss_pkg::ctx_type               wr_data;
   logic [jss_pkg::CTX_W-1:0]      rd_data;

   jss_pkg::ctx_type               t;
   jss_pkg::op_type                op;
   logic                           accept, key_slot, key_pend, is_obj, multi;
   logic [2:0]                     pre_n;

   assign level_m1 = level_ff - jss_pkg::LEVEL_W'(1);
   assign level_m2 = level_ff - jss_pkg::LEVEL_W'(2);
   assign wr_addr  = level_m1[jss_pkg::ADDR_W-1:0];
   // The entry below the top is fetched while the top is popped.
   assign rd_addr  = level_m2[jss_pkg::ADDR_W-1:0];

   assign op       = jss_pkg::op_type'(req_chan.op);
   assign t        = (level_ff == '0) ? jss_pkg::C_ROOT : top_ff;
   assign key_slot = (t == jss_pkg::C_LOB) || (t == jss_pkg::C_LOV) ||
                     (t == jss_pkg::C_MOB) || (t == jss_pkg::C_MOV);
   assign key_pend = (t == jss_pkg::C_LOK) || (t == jss_pkg::C_MOK);
   assign is_obj   = (op == jss_pkg::OP_LOBJ) || (op == jss_pkg::OP_OBJ);
   assign multi    = ((op == jss_pkg::OP_ARR) || (op == jss_pkg::OP_OBJ)) &&
                     !((t == jss_pkg::C_LAB) || (t == jss_pkg::C_LAI) || (t == jss_pkg::C_LOK));

   assign req_chan.ready = (state_ff == S_IDLE) && !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   jss_ram #(
      .WIDTH (jss_pkg::CTX_W),
      .DEPTH (jss_pkg::MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      level_in  = level_ff;
      top_in    = top_ff;
      linear_in = linear_ff;
      q_push    = 1'b0;
      q_data    = '0;
      wr_en     = 1'b0;
      wr_data   = top_ff;
      pre_n     = 3'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op)
                  jss_pkg::OP_LIT: begin
                     q_push = 1'b1;
                     if (t == jss_pkg::C_ROOT) begin
                        q_data = jss_pkg::err_cmd(jss_pkg::E_LIT_ROOT);
                     end else if (key_slot && !req_chan.is_string) begin
                        q_data = jss_pkg::err_cmd(jss_pkg::E_NOT_STR);
                     end else begin
                        q_data.tag  = req_chan.literal_handle;
                        q_data.last = 1'b1;
                        case (t)
                           jss_pkg::C_LAB: begin
                              q_data.count  = 3'd2;
                              q_data.act[0] = jss_pkg::A_SPACE;
                              q_data.act[1] = jss_pkg::A_LIT;
                              top_in = jss_pkg::C_LAI;
                           end
                           jss_pkg::C_LAI: begin
                              q_data.count  = 3'd3;
                              q_data.act[0] = jss_pkg::A_COMMA;
                              q_data.act[1] = jss_pkg::A_SPACE;
                              q_data.act[2] = jss_pkg::A_LIT;
                           end
                           jss_pkg::C_LOB: begin
                              q_data.count  = 3'd4;
                              q_data.act[0] = jss_pkg::A_SPACE;
                              q_data.act[1] = jss_pkg::A_LIT;
                              q_data.act[2] = jss_pkg::A_SPACE;
                              q_data.act[3] = jss_pkg::A_COLON;
                              top_in = jss_pkg::C_LOK;
                           end
                           jss_pkg::C_LOK: begin
                              q_data.count  = 3'd2;
                              q_data.act[0] = jss_pkg::A_SPACE;
                              q_data.act[1] = jss_pkg::A_LIT;
                              top_in = jss_pkg::C_LOV;
                           end
                           jss_pkg::C_LOV: begin
                              q_data.count  = 3'd5;
                              q_data.act[0] = jss_pkg::A_COMMA;
                              q_data.act[1] = jss_pkg::A_SPACE;
                              q_data.act[2] = jss_pkg::A_LIT;
                              q_data.act[3] = jss_pkg::A_SPACE;
                              q_data.act[4] = jss_pkg::A_COLON;
                              top_in = jss_pkg::C_LOK;
                           end
                           jss_pkg::C_MAB: begin
                              q_data.count  = 3'd2;
                              q_data.act[0] = jss_pkg::A_NEWLINE;
                              q_data.act[1] = jss_pkg::A_LIT;
                              top_in = jss_pkg::C_MAI;
                           end
                           jss_pkg::C_MAI: begin
                              q_data.count  = 3'd3;
                              q_data.act[0] = jss_pkg::A_COMMA;
                              q_data.act[1] = jss_pkg::A_NEWLINE;
                              q_data.act[2] = jss_pkg::A_LIT;
                           end
                           jss_pkg::C_MOB: begin
                              q_data.count  = 3'd4;
                              q_data.act[0] = jss_pkg::A_NEWLINE;
                              q_data.act[1] = jss_pkg::A_LIT;
                              q_data.act[2] = jss_pkg::A_SPACE;
                              q_data.act[3] = jss_pkg::A_COLON;
                              top_in = jss_pkg::C_MOK;
                           end
                           jss_pkg::C_MOK: begin
                              q_data.count  = 3'd2;
                              q_data.act[0] = jss_pkg::A_SPACE;
                              q_data.act[1] = jss_pkg::A_LIT;
                              top_in = jss_pkg::C_MOV;
                           end
                           default: begin
                              q_data.count  = 3'd5;
                              q_data.act[0] = jss_pkg::A_COMMA;
                              q_data.act[1] = jss_pkg::A_NEWLINE;
                              q_data.act[2] = jss_pkg::A_LIT;
                              q_data.act[3] = jss_pkg::A_SPACE;
                              q_data.act[4] = jss_pkg::A_COLON;
                              top_in = jss_pkg::C_MOK;
                           end
                        endcase
                     end
                  end

                  jss_pkg::OP_LARR, jss_pkg::OP_LOBJ, jss_pkg::OP_ARR, jss_pkg::OP_OBJ: begin
                     q_push = 1'b1;
                     if (key_slot) begin
                        q_data = jss_pkg::err_cmd(jss_pkg::E_BEGIN_KEY);
                     end else if (level_ff == jss_pkg::LEVEL_W'(jss_pkg::MAX_DEPTH)) begin
                        q_data = jss_pkg::err_cmd(jss_pkg::E_OVERFLOW);
                     end else begin
                        q_data.last = 1'b1;
                        // The separator in front of the bracket also advances
                        // the enclosing context; that updated context is saved.
                        case (t)
                           jss_pkg::C_LAB: begin
                              pre_n = 3'd1; q_data.act[0] = jss_pkg::A_SPACE;
                              wr_data = jss_pkg::C_LAI;
                           end
                           jss_pkg::C_MAB: begin
                              pre_n = 3'd1; q_data.act[0] = jss_pkg::A_NEWLINE;
                              wr_data = jss_pkg::C_MAI;
                           end
                           jss_pkg::C_LAI: begin
                              pre_n = 3'd2;
                              q_data.act[0] = jss_pkg::A_COMMA;
                              q_data.act[1] = jss_pkg::A_SPACE;
                           end
                           jss_pkg::C_MAI: begin
                              pre_n = 3'd2;
                              q_data.act[0] = jss_pkg::A_COMMA;
                              q_data.act[1] = jss_pkg::A_NEWLINE;
                           end
                           jss_pkg::C_LOK: begin
                              pre_n = 3'd1; q_data.act[0] = jss_pkg::A_SPACE;
                              wr_data = jss_pkg::C_LOV;
                           end
                           jss_pkg::C_MOK: begin
                              pre_n = 3'd1; q_data.act[0] = jss_pkg::A_SPACE;
                              wr_data = jss_pkg::C_MOV;
                           end
                           default: begin
                              pre_n = 3'd0;
                           end
                        endcase
                        q_data.act[pre_n] = is_obj ? jss_pkg::A_LBRACE : jss_pkg::A_LBRACK;
                        if (multi) begin
                           q_data.act[pre_n + 3'd1] = jss_pkg::A_IN;
                           q_data.count = pre_n + 3'd2;
                        end else begin
                           q_data.count = pre_n + 3'd1;
                        end
                        wr_en    = (level_ff != '0);
                        level_in = level_ff + jss_pkg::LEVEL_W'(1);
                        if (is_obj) begin
                           top_in = multi ? jss_pkg::C_MOB : jss_pkg::C_LOB;
                        end else begin
                           top_in = multi ? jss_pkg::C_MAB : jss_pkg::C_LAB;
                        end
                     end
                  end

                  jss_pkg::OP_END: begin
                     q_push = 1'b1;
                     if (t == jss_pkg::C_ROOT) begin
                        q_data = jss_pkg::err_cmd(jss_pkg::E_END_ROOT);
                     end else if (key_pend) begin
                        q_data = jss_pkg::err_cmd(jss_pkg::E_END_KEY);
                     end else begin
                        q_data   = jss_pkg::close_cmd(t, 1'b1);
                        level_in = level_m1;
                        if (level_ff > jss_pkg::LEVEL_W'(1)) begin
                           state_in = S_FETCH;
                        end
                     end
                  end

                  default: begin
                     if (key_pend) begin
                        q_push = 1'b1;
                        q_data = jss_pkg::err_cmd(jss_pkg::E_END_KEY);
                     end else if (level_ff == '0) begin
                        if (op == jss_pkg::OP_FIN) begin
                           q_push        = 1'b1;
                           q_data.count  = 3'd1;
                           q_data.act[0] = jss_pkg::A_NEWLINE;
                           q_data.last   = 1'b1;
                        end
                     end else begin
                        linear_in = (op == jss_pkg::OP_LFIN);
                        state_in  = S_UNWIND;
                     end
                  end
               endcase
            end
         end

         S_FETCH: begin
            top_in   = jss_pkg::ctx_type'(rd_data);
            state_in = S_IDLE;
         end

         S_UNWIND: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_data   = jss_pkg::close_cmd(top_ff,
                             linear_ff && (level_ff == jss_pkg::LEVEL_W'(1)));
               level_in = level_m1;
               if (level_ff > jss_pkg::LEVEL_W'(1)) begin
                  state_in = S_UNW_FETCH;
               end else if (linear_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_UNW_FETCH: begin
            top_in   = jss_pkg::ctx_type'(rd_data);
            state_in = S_UNWIND;
         end

         S_FINISH: begin
            if (!q_full) begin
               q_push        = 1'b1;
               q_data.count  = 3'd1;
               q_data.act[0] = jss_pkg::A_NEWLINE;
               q_data.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         level_ff  <= '0;
         linear_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         level_ff  <= level_in;
         linear_ff <= linear_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

endmodule

// ===== design/jss_back.sv =====
module jss_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  jss_pkg::cmd_type q_data,
   output logic             q_pop,
   jss_rsp_if.source        rsp_chan
);

   jss_pkg::cmd_type   cmd_ff, cmd_in;
   logic               busy_ff, busy_in;
   logic [2:0]         idx_ff, idx_in;
   jss_pkg::action_type act;
   logic               last_step, fire;

   assign act       = cmd_ff.act[idx_ff];
   assign last_step = (idx_ff == cmd_ff.count - 3'd1);
   assign fire      = busy_ff && rsp_chan.ready;
   assign q_pop     = q_valid && (!busy_ff || (fire && last_step));

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.action      = act;
   assign rsp_chan.literal_tag = (act == jss_pkg::A_LIT) ? cmd_ff.tag : '0;
   assign rsp_chan.error_code  = (act == jss_pkg::A_ERR) ? cmd_ff.err : jss_pkg::E_NONE;
   assign rsp_chan.last        = cmd_ff.last && last_step;

   always_comb begin
      cmd_in  = cmd_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         cmd_in  = q_data;
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (fire) begin
         if (last_step) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

// ===== design/json_structure_sequencer.sv =====
// JSON writer structure sequencer. Each token on req_chan turns into at most five
// formatter actions on rsp_chan, delivered one per cycle while rsp_chan is ready,
// except that a finish token closes every open context in turn with up to three
// actions each, and a one-line finish at the root yields none. The front end takes
// a token when the command queue has room, except that an end which uncovers an
// outer context passes through a fetch state that reads that context back from
// the nesting stack RAM, and a finish steps through an unwind state per open
// context, with a fetch state between them, then a finish state for the trailing
// newline unless it is a one-line finish. Sustained throughput is therefore set
// by the back end at one action per cycle while rsp_chan is ready. Errors produce
// a single error action and leave the nesting state untouched. The nesting stack
// holds up to sixteen contexts; a deeper begin is refused with an overflow error.
module json_structure_sequencer (
   input  logic       clock,
   input  logic       reset,
   jss_req_if.sink    req_chan,
   jss_rsp_if.source  rsp_chan
);

   logic             q_push, q_full, q_pop, q_valid;
   jss_pkg::cmd_type q_wdata, q_rdata;

   jss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_push   (q_push),
      .q_data   (q_wdata),
      .q_full   (q_full)
   );

   jss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .not_empty (q_valid)
   );

   jss_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== verif/json_structure_sequencer_tb.sv =====
module json_structure_sequencer_tb;

   localparam int RANDOM_TOKENS = 185;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      jss_pkg::ctx_type [jss_pkg::MAX_DEPTH-1:0] stk;
      logic [jss_pkg::LEVEL_W-1:0]               level;
   } nest_type;

   typedef struct packed {
      logic                      drain;
      jss_pkg::op_type           op;
      logic                      is_string;
      logic [jss_pkg::TAG_W-1:0] handle;
   } token_type;

   typedef struct packed {
      jss_pkg::action_type       action;
      logic [jss_pkg::TAG_W-1:0] tag;
      jss_pkg::err_type          err;
      logic                      last;
   } fmt_action_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jss_req_if req_if ();
   jss_rsp_if rsp_if ();

   json_structure_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   token_type      token_q [$];
   fmt_action_type expected_q [$];
   nest_type       plan_state = '0;
   nest_type       nest = '0;
   token_type      cur_tok;
   logic           drain_next = 1'b0;
   logic           req_fire = 1'b0;
   logic           rsp_fire = 1'b0;
   logic           stim_done = 1'b0;
   int             req_gap = 0, req_calm = 0, rsp_stall = 0, rsp_calm = 0, idle_cycles = 0;
   int             tokens_taken = 0, actions_checked = 0, error_actions = 0;
   int             overflows = 0, deepest = 0, mismatches = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one token to a nesting state and returns the formatter actions it yields,
   // or an error code, in which case the state is left as it was.
   function automatic jss_pkg::err_type advance_nesting(inout nest_type st,
                                                        input jss_pkg::op_type op,
                                                        input logic str,
                                                        output jss_pkg::action_type seq [$]);
      jss_pkg::ctx_type top, c;
      logic             keyslot, multi, is_obj;
      int               n_close;
      seq = {};
      top = (st.level == 0) ? jss_pkg::C_ROOT : st.stk[st.level - 1];
      c = top;
      keyslot = top inside {jss_pkg::C_LOB, jss_pkg::C_LOV, jss_pkg::C_MOB, jss_pkg::C_MOV};
      case (op)
         jss_pkg::OP_LIT: begin
            if (top == jss_pkg::C_ROOT) return jss_pkg::E_LIT_ROOT;
            if (keyslot && !str) return jss_pkg::E_NOT_STR;
            case (top)
               jss_pkg::C_LAB: begin
                  seq = '{jss_pkg::A_SPACE, jss_pkg::A_LIT}; c = jss_pkg::C_LAI;
               end
               jss_pkg::C_LAI: seq = '{jss_pkg::A_COMMA, jss_pkg::A_SPACE, jss_pkg::A_LIT};
               jss_pkg::C_LOB: begin
                  seq = '{jss_pkg::A_SPACE, jss_pkg::A_LIT, jss_pkg::A_SPACE,
                          jss_pkg::A_COLON};
                  c = jss_pkg::C_LOK;
               end
               jss_pkg::C_LOK: begin
                  seq = '{jss_pkg::A_SPACE, jss_pkg::A_LIT}; c = jss_pkg::C_LOV;
               end
               jss_pkg::C_LOV: begin
                  seq = '{jss_pkg::A_COMMA, jss_pkg::A_SPACE, jss_pkg::A_LIT,
                          jss_pkg::A_SPACE, jss_pkg::A_COLON};
                  c = jss_pkg::C_LOK;
               end
               jss_pkg::C_MAB: begin
                  seq = '{jss_pkg::A_NEWLINE, jss_pkg::A_LIT}; c = jss_pkg::C_MAI;
               end
               jss_pkg::C_MAI: seq = '{jss_pkg::A_COMMA, jss_pkg::A_NEWLINE, jss_pkg::A_LIT};
               jss_pkg::C_MOB: begin
                  seq = '{jss_pkg::A_NEWLINE, jss_pkg::A_LIT, jss_pkg::A_SPACE,
                          jss_pkg::A_COLON};
                  c = jss_pkg::C_MOK;
               end
               jss_pkg::C_MOK: begin
                  seq = '{jss_pkg::A_SPACE, jss_pkg::A_LIT}; c = jss_pkg::C_MOV;
               end
               default: begin
                  seq = '{jss_pkg::A_COMMA, jss_pkg::A_NEWLINE, jss_pkg::A_LIT,
                          jss_pkg::A_SPACE, jss_pkg::A_COLON};
                  c = jss_pkg::C_MOK;
               end
            endcase
            st.stk[st.level - 1] = c;
         end
         jss_pkg::OP_LARR, jss_pkg::OP_LOBJ, jss_pkg::OP_ARR, jss_pkg::OP_OBJ: begin
            is_obj = (op == jss_pkg::OP_LOBJ || op == jss_pkg::OP_OBJ);
            // A multi-line container opened inside a one-line one stays on one line.
            multi = (op == jss_pkg::OP_ARR || op == jss_pkg::OP_OBJ) &&
                    !(top inside {jss_pkg::C_LAB, jss_pkg::C_LAI, jss_pkg::C_LOK});
            if (keyslot) return jss_pkg::E_BEGIN_KEY;
            if (st.level >= jss_pkg::MAX_DEPTH) return jss_pkg::E_OVERFLOW;
            case (top)
               jss_pkg::C_LAB: begin
                  seq = '{jss_pkg::A_SPACE}; c = jss_pkg::C_LAI;
               end
               jss_pkg::C_MAB: begin
                  seq = '{jss_pkg::A_NEWLINE}; c = jss_pkg::C_MAI;
               end
               jss_pkg::C_LAI: seq = '{jss_pkg::A_COMMA, jss_pkg::A_SPACE};
               jss_pkg::C_MAI: seq = '{jss_pkg::A_COMMA, jss_pkg::A_NEWLINE};
               jss_pkg::C_LOK: begin
                  seq = '{jss_pkg::A_SPACE}; c = jss_pkg::C_LOV;
               end
               jss_pkg::C_MOK: begin
                  seq = '{jss_pkg::A_SPACE}; c = jss_pkg::C_MOV;
               end
               default: ;
            endcase
            if (st.level != 0) st.stk[st.level - 1] = c;
            if (is_obj) seq = {seq, jss_pkg::A_LBRACE};
            else seq = {seq, jss_pkg::A_LBRACK};
            if (multi) seq = {seq, jss_pkg::A_IN};
            if (is_obj) st.stk[st.level] = multi ? jss_pkg::C_MOB : jss_pkg::C_LOB;
            else st.stk[st.level] = multi ? jss_pkg::C_MAB : jss_pkg::C_LAB;
            st.level = st.level + 1'b1;
         end
         default: begin
            if (op == jss_pkg::OP_END && top == jss_pkg::C_ROOT) return jss_pkg::E_END_ROOT;
            if (top == jss_pkg::C_LOK || top == jss_pkg::C_MOK) return jss_pkg::E_END_KEY;
            n_close = (op == jss_pkg::OP_END) ? 1 : int'(st.level);
            repeat (n_close) begin
               c = st.stk[st.level - 1];
               if (c inside {jss_pkg::C_MAB, jss_pkg::C_MAI, jss_pkg::C_MOB, jss_pkg::C_MOV})
                  seq = {seq, jss_pkg::A_OUT};
               if (c == jss_pkg::C_MAI || c == jss_pkg::C_MOV) seq = {seq, jss_pkg::A_NEWLINE};
               if (c == jss_pkg::C_LAI || c == jss_pkg::C_LOV) seq = {seq, jss_pkg::A_SPACE};
               if (c inside {jss_pkg::C_LAB, jss_pkg::C_LAI, jss_pkg::C_MAB, jss_pkg::C_MAI})
                  seq = {seq, jss_pkg::A_RBRACK};
               else
                  seq = {seq, jss_pkg::A_RBRACE};
               st.level = st.level - 1'b1;
            end
            if (op == jss_pkg::OP_FIN) seq = {seq, jss_pkg::A_NEWLINE};
         end
      endcase
      return jss_pkg::E_NONE;
   endfunction

   // Most gaps are zero or short, a few are long, and now and then a calm stretch
   // of back-to-back transfers follows.
   function automatic int next_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 4) begin
         calm = $urandom_range(40, 15);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 6);
   endfunction

   function automatic logic [jss_pkg::TAG_W-1:0] rand_tag();
      return jss_pkg::TAG_W'($urandom());
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic jss_pkg::op_type rand_begin();
      return jss_pkg::op_type'($urandom_range(4, 1));
   endfunction

   task automatic queue_token(input jss_pkg::op_type op, input logic str,
                              input logic [jss_pkg::TAG_W-1:0] h);
      jss_pkg::action_type scratch [$];
      token_type           tok;
      void'(advance_nesting(plan_state, op, str, scratch));
      tok = '{drain_next, op, str, h};
      token_q = {token_q, tok};
      drain_next = 1'b0;
   endtask

   task automatic predict_actions(input jss_pkg::op_type op, input logic str,
                                  input logic [jss_pkg::TAG_W-1:0] h);
      jss_pkg::action_type seq [$];
      jss_pkg::err_type    code;
      fmt_action_type      item;
      code = advance_nesting(nest, op, str, seq);
      if (code != jss_pkg::E_NONE) begin
         item = '{jss_pkg::A_ERR, '0, code, 1'b1};
         expected_q = {expected_q, item};
         if (code == jss_pkg::E_OVERFLOW) overflows++;
      end else begin
         foreach (seq[i]) begin
            item.action = seq[i];
            item.tag    = (seq[i] == jss_pkg::A_LIT) ? h : '0;
            item.err    = jss_pkg::E_NONE;
            item.last   = (i == seq.size() - 1);
            expected_q = {expected_q, item};
         end
      end
      if (nest.level > deepest) deepest = nest.level;
   endtask

   task automatic check_action();
      fmt_action_type got, want;
      got = '{jss_pkg::action_type'(rsp_if.action), rsp_if.literal_tag,
              jss_pkg::err_type'(rsp_if.error_code), rsp_if.last};
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected action, expected none, got act=%0d tag=%h err=%0d last=%b",
                  $time, got.action, got.tag, got.err, got.last);
         mismatches++;
      end else begin
         want = expected_q.pop_front();
         actions_checked++;
         if (want.action == jss_pkg::A_ERR) error_actions++;
         if (got !== want) begin
            $display("%0t: action mismatch: expected act=%0d tag=%h err=%0d last=%b,",
                     $time, want.action, want.tag, want.err, want.last);
            $display("%0t:    got act=%0d tag=%h err=%0d last=%b",
                     $time, got.action, got.tag, got.err, got.last);
            mismatches++;
         end
      end
   endtask

   // Token driver: holds an item until it is taken, then idles for a random gap.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_if.valid || req_fire) begin
            if (req_gap > 0) begin
               req_if.valid <= 1'b0;
               req_gap--;
            end else if (token_q.size() != 0 &&
                         !(token_q[0].drain && expected_q.size() != 0)) begin
               cur_tok = token_q.pop_front();
               req_if.valid          <= 1'b1;
               req_if.op             <= cur_tok.op;
               req_if.is_string      <= cur_tok.is_string;
               req_if.literal_handle <= cur_tok.handle;
               req_gap = next_gap(req_calm);
            end else begin
               req_if.valid <= 1'b0;
               if (token_q.size() == 0) stim_done = 1'b1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) rsp_stall = next_gap(rsp_calm);
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         rsp_fire <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            tokens_taken++;
            predict_actions(jss_pkg::op_type'(req_if.op), req_if.is_string,
                            req_if.literal_handle);
         end
         if (rsp_if.valid && rsp_if.ready) check_action();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d actions still expected", $time,
                  idle_cycles, expected_q.size());
         $display("** json_structure_sequencer: FAILED **");
         $finish;
      end
   end

   initial begin
      int               produced, budget, pick, docs;
      logic             deep;
      jss_pkg::ctx_type top;

      req_if.valid          = 1'b0;
      req_if.op             = jss_pkg::OP_LIT;
      req_if.is_string      = 1'b0;
      req_if.literal_handle = '0;
      rsp_if.ready          = 1'b0;

      // Root-level corner cases.
      queue_token(jss_pkg::OP_LFIN, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_LIT, 1'b1, 16'hFFFF);
      queue_token(jss_pkg::OP_END, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_FIN, 1'b1, 16'hFFFF);
      // An empty multi-line array still balances its indent.
      queue_token(jss_pkg::OP_ARR, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_END, 1'b0, 16'h0000);
      // Multi-line object with key errors and a nested one-line object.
      queue_token(jss_pkg::OP_OBJ, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_LIT, 1'b0, 16'h1234);
      queue_token(jss_pkg::OP_LIT, 1'b1, 16'h0001);
      queue_token(jss_pkg::OP_END, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_ARR, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_LIT, 1'b0, 16'h8000);
      queue_token(jss_pkg::OP_LOBJ, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_ARR, 1'b1, 16'h0000);
      queue_token(jss_pkg::OP_LIT, 1'b1, 16'h5A5A);
      queue_token(jss_pkg::OP_OBJ, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_FIN, 1'b0, 16'h0000);
      // One-line array with a multi-line begin that falls back to one line.
      queue_token(jss_pkg::OP_LARR, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_ARR, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_LIT, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_LFIN, 1'b0, 16'h0000);
      // Finish with a key still waiting for its value.
      queue_token(jss_pkg::OP_LOBJ, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_LIT, 1'b1, 16'hA5A5);
      queue_token(jss_pkg::OP_LFIN, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_LIT, 1'b0, 16'h7FFF);
      queue_token(jss_pkg::OP_LIT, 1'b1, 16'h00FF);
      queue_token(jss_pkg::OP_LIT, 1'b1, 16'hFF00);
      queue_token(jss_pkg::OP_END, 1'b0, 16'h0000);
      // Fill the stack, push once more, then unwind the deepest possible finish.
      drain_next = 1'b1;
      repeat (jss_pkg::MAX_DEPTH) queue_token(jss_pkg::OP_ARR, 1'b0, 16'h0000);
      queue_token(jss_pkg::OP_ARR, 1'b1, 16'hFFFF);
      queue_token(jss_pkg::OP_LIT, 1'b1, 16'hC3C3);
      queue_token(jss_pkg::OP_FIN, 1'b0, 16'h0000);

      // Random documents with well-formed structure, plus some noise tokens.
      produced = 0;
      budget = 0;
      docs = 0;
      deep = 1'b0;
      drain_next = 1'b1;
      while (produced < RANDOM_TOKENS) begin
         top = (plan_state.level == 0) ? jss_pkg::C_ROOT
                                       : plan_state.stk[plan_state.level - 1];
         pick = $urandom_range(99);
         if (pick < 8) begin
            queue_token(jss_pkg::op_type'($urandom_range(7)), rand_bit(), rand_tag());
         end else if (top == jss_pkg::C_ROOT) begin
            docs++;
            deep = ($urandom_range(99) < 12);
            budget = deep ? $urandom_range(45, 30) : $urandom_range(20, 2);
            if (docs % 5 == 0) drain_next = 1'b1;
            queue_token(rand_begin(), rand_bit(), rand_tag());
         end else if (top == jss_pkg::C_LOK || top == jss_pkg::C_MOK) begin
            // Apart from noise tokens, a key is followed by its value.
            if (budget > 0 && $urandom_range(99) < (deep ? 85 : 35))
               queue_token(rand_begin(), rand_bit(), rand_tag());
            else
               queue_token(jss_pkg::OP_LIT, rand_bit(), rand_tag());
         end else if (budget <= 0) begin
            pick = $urandom_range(99);
            if (pick < 30)
               queue_token(jss_pkg::OP_FIN, rand_bit(), rand_tag());
            else if (pick < 50)
               queue_token(jss_pkg::OP_LFIN, rand_bit(), rand_tag());
            else
               queue_token(jss_pkg::OP_END, rand_bit(), rand_tag());
         end else if (top inside {jss_pkg::C_LOB, jss_pkg::C_LOV,
                                  jss_pkg::C_MOB, jss_pkg::C_MOV}) begin
            if (deep || $urandom_range(99) < 75)
               queue_token(jss_pkg::OP_LIT, deep || ($urandom_range(99) < 93), rand_tag());
            else
               queue_token(jss_pkg::OP_END, rand_bit(), rand_tag());
         end else begin
            pick = $urandom_range(99);
            if (pick < (deep ? 85 : 25))
               queue_token(rand_begin(), rand_bit(), rand_tag());
            else if (deep || pick < 70)
               queue_token(jss_pkg::OP_LIT, rand_bit(), rand_tag());
            else
               queue_token(jss_pkg::OP_END, rand_bit(), rand_tag());
         end
         budget--;
         produced++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (stim_done);
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d tokens; checked %0d formatter actions, %0d errors (%0d overflows).",
               tokens_taken, actions_checked, error_actions, overflows);
      $display("Nesting went %0d levels deep with random stalls on both channels.", deepest);
      if (mismatches == 0) begin
         $display("** json_structure_sequencer: PASSED **");
      end else begin
         $display("%0d mismatching actions", mismatches);
         $display("** json_structure_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
